// ===== src/cfa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the checked signed ALU: opcodes, status codes, item kinds and sizes.
// No dependencies; every other file of the block imports it.
package cfa_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int OUT_WIDTH      = 64;
    localparam int OP_WIDTH       = 3;
    localparam int ST_WIDTH       = 2;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_NOT = 3'd5
    } t_opcode;

    typedef enum logic [ST_WIDTH-1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_DONE = 2'd0,
        K_MUL  = 2'd1,
        K_DIV  = 2'd2,
        K_MOD  = 2'd3
    } t_kind;

    // kind + two sign flags + status + four operand-wide fields
    function automatic int item_width(input int w);
        return 6 + 4 * w;
    endfunction

endpackage

// ===== src/cfa_front.sv =====
`timescale 1ns / 1ps
// Front stage: accepts an item, finishes add, subtract, not and the error cases,
// and passes every item, finished or not, on to the back pipeline as a classified item. Uses cfa_pkg.
module cfa_front #(
    parameter int W  = cfa_pkg::DATA_WIDTH_DEF,
    parameter int IW = cfa_pkg::item_width(cfa_pkg::DATA_WIDTH_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cfa_pkg::OP_WIDTH-1:0]  i_opcode,
    input  logic [cfa_pkg::OUT_WIDTH-1:0] i_operand_a,
    input  logic [cfa_pkg::OUT_WIDTH-1:0] i_operand_b,
    output logic                          o_item_valid,
    input  logic                          i_item_ready,
    output logic [IW-1:0]                 o_item
);
    import cfa_pkg::*;

    typedef struct packed {
        t_kind         kind;
        logic          neg;
        logic          neg_a;
        t_status       st;
        logic [W-1:0]  b_s;
        logic [W-1:0]  res;
        logic [W-1:0]  mag_a;
        logic [W-1:0]  mag_b;
    } t_item;

    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    t_item        r_item, n_item;
    logic         r_vld;
    logic [W-1:0] a_s, b_s, sum, dif;
    logic         sa, sb;

    always_comb begin
        a_s = i_operand_a[W-1:0];
        b_s = i_operand_b[W-1:0];
        sa  = a_s[W-1];
        sb  = b_s[W-1];
        sum = a_s + b_s;
        dif = a_s - b_s;
        n_item.kind  = K_DONE;
        n_item.neg   = sa ^ sb;
        n_item.neg_a = sa;
        n_item.st    = ST_OK;
        n_item.b_s   = b_s;
        n_item.res   = '0;
        n_item.mag_a = sa ? (~a_s + 1'b1) : a_s;
        n_item.mag_b = sb ? (~b_s + 1'b1) : b_s;
        unique case (i_opcode)
            OP_ADD: begin
                if (sa == sb && sum[W-1] != sa) n_item.st = ST_OVF;
                else n_item.res = sum;
            end
            OP_SUB: begin
                if (sa != sb && dif[W-1] != sa) n_item.st = ST_OVF;
                else n_item.res = dif;
            end
            OP_MUL: n_item.kind = K_MUL;
            OP_DIV: begin
                if (b_s == '0) n_item.st = ST_DIVZ;
                else if (a_s == MIN_VAL && b_s == '1) n_item.st = ST_OVF;
                else n_item.kind = K_DIV;
            end
            OP_MOD: begin
                if (b_s == '0) n_item.st = ST_DIVZ;
                else n_item.kind = K_MOD;
            end
            OP_NOT: n_item.res = ~a_s;
            default: ;
        endcase
    end

    assign o_in_ready   = !r_vld || i_item_ready;
    assign o_item_valid = r_vld;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== src/cfa_fifo.sv =====
`timescale 1ns / 1ps
// Short queue between the front stage and the back pipeline.
// Uses cfa_pkg for its depth.
module cfa_fifo #(
    parameter int IW = cfa_pkg::item_width(cfa_pkg::DATA_WIDTH_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [IW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [IW-1:0] o_data
);
    import cfa_pkg::*;

    logic [IW-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               push, pop;

    assign o_ready = r_cnt != (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            if (push && !pop) r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/cfa_back.sv =====
`timescale 1ns / 1ps
// Back pipeline: one quotient bit per stage, split multiply over the first two stages,
// then sign fix-up and the modulo correction. Uses cfa_pkg.
module cfa_back #(
    parameter int W  = cfa_pkg::DATA_WIDTH_DEF,
    parameter int IW = cfa_pkg::item_width(cfa_pkg::DATA_WIDTH_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  logic [IW-1:0]                 i_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cfa_pkg::OUT_WIDTH-1:0] o_result_value,
    output logic [cfa_pkg::ST_WIDTH-1:0]  o_status
);
    import cfa_pkg::*;

    localparam int D  = W + 2;
    localparam int HW = (W + 1) / 2;
    localparam int LW = W / 2;
    localparam int PW = 2 * W;
    localparam int QW = 2 * HW;
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

    typedef struct packed {
        t_kind         kind;
        logic          neg;
        logic          neg_a;
        t_status       st;
        logic [W-1:0]  b_s;
        logic [W-1:0]  res;
        logic [W-1:0]  mag_a;
        logic [W-1:0]  mag_b;
    } t_item;

    typedef struct packed {
        t_kind         kind;
        logic          neg;
        logic          neg_a;
        t_status       st;
        logic [W-1:0]  b_s;
        logic [W-1:0]  res;
        logic [W-1:0]  rem;
        logic [W-1:0]  quo;
        logic [W-1:0]  dvs;
        logic [QW-1:0] p_hh;
        logic [QW-1:0] p_hl;
        logic [QW-1:0] p_lh;
        logic [QW-1:0] p_ll;
        logic [PW-1:0] prod;
    } t_stage;

    function automatic t_stage div_step(input t_stage s);
        t_stage     o;
        logic [W:0] t;
        o = s;
        t = {s.rem, s.quo[W-1]};
        if (t >= {1'b0, s.dvs}) begin
            o.rem = W'(t - {1'b0, s.dvs});
            o.quo = {s.quo[W-2:0], 1'b1};
        end else begin
            o.rem = t[W-1:0];
            o.quo = {s.quo[W-2:0], 1'b0};
        end
        return o;
    endfunction

    t_item  head;
    t_stage r_stg [D];
    t_stage n_stg [D];
    logic   r_vld [D];
    logic   en;

    assign head         = i_item;
    assign en           = !r_vld[D-1] || i_out_ready;
    assign o_item_ready = en;

    always_comb begin
        t_stage s;
        s.kind  = head.kind;
        s.neg   = head.neg;
        s.neg_a = head.neg_a;
        s.st    = head.st;
        s.b_s   = head.b_s;
        s.res   = head.res;
        s.rem   = '0;
        s.quo   = head.mag_a;
        s.dvs   = head.mag_b;
        s.p_hh  = QW'(head.mag_a[W-1:LW]) * QW'(head.mag_b[W-1:LW]);
        s.p_hl  = QW'(head.mag_a[W-1:LW]) * QW'(head.mag_b[LW-1:0]);
        s.p_lh  = QW'(head.mag_a[LW-1:0]) * QW'(head.mag_b[W-1:LW]);
        s.p_ll  = QW'(head.mag_a[LW-1:0]) * QW'(head.mag_b[LW-1:0]);
        s.prod  = '0;
        n_stg[0] = div_step(s);
    end

    always_comb begin
        t_stage s;
        s = r_stg[0];
        s.prod = (PW'(s.p_hh) << (2 * LW)) + (PW'(s.p_hl) << LW)
               + (PW'(s.p_lh) << LW) + PW'(s.p_ll);
        n_stg[1] = div_step(s);
    end

    for (genvar k = 2; k < W; k++) begin : g_div
        always_comb begin
            n_stg[k] = div_step(r_stg[k-1]);
        end
    end

    always_comb begin
        t_stage       s;
        logic [W-1:0] lo;
        s  = r_stg[W-1];
        lo = s.prod[W-1:0];
        unique case (s.kind)
            K_MUL: begin
                if (s.prod[PW-1:W] != '0 || lo > (s.neg ? MIN_VAL : MAX_VAL)) begin
                    s.st  = ST_OVF;
                    s.res = '0;
                end else begin
                    s.res = s.neg ? (~lo + 1'b1) : lo;
                end
            end
            K_DIV:   s.res = s.neg ? (~s.quo + 1'b1) : s.quo;
            K_MOD:   s.res = s.neg_a ? (~s.rem + 1'b1) : s.rem;
            K_DONE:  ;
        endcase
        n_stg[W] = s;
    end

    always_comb begin
        t_stage       s;
        logic [W-1:0] sum;
        s   = r_stg[W];
        sum = s.res + s.b_s;
        if (s.kind == K_MOD && s.res[W-1]) begin
            if (s.res[W-1] == s.b_s[W-1] && sum[W-1] != s.res[W-1]) begin
                s.st  = ST_OVF;
                s.res = '0;
            end else begin
                s.res = sum;
            end
        end
        n_stg[W+1] = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_item_valid;
            for (int k = 1; k < D; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < D; k++) r_stg[k] <= n_stg[k];
        end
    end

    assign o_out_valid    = r_vld[D-1];
    assign o_result_value = OUT_WIDTH'($signed(r_stg[D-1].res));
    assign o_status       = r_stg[D-1].st;

endmodule

// ===== src/checked_signed_alu.sv =====
`timescale 1ns / 1ps
// Top level of the checked signed ALU: front stage, queue and back pipeline.
// Depends on cfa_pkg, cfa_front, cfa_fifo and cfa_back.
//
//  channel | valid        | ready        | payload
//  input   | i_in_valid   | o_in_ready   | i_opcode, i_operand_a, i_operand_b
//  output  | o_out_valid  | i_out_ready  | o_result_value, o_status
//
// One item per cycle sustained while i_out_ready is not held low.
// The back pipeline has one stage per quotient bit plus two fix-up stages.
// Reset is synchronous, active low, and empties all stages and the queue.
// Output stalls hold the back pipeline; the four-entry queue and the front
// register keep taking items until they fill.
module checked_signed_alu #(
    parameter int DATA_WIDTH = cfa_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cfa_pkg::OP_WIDTH-1:0]  i_opcode,
    input  logic [cfa_pkg::OUT_WIDTH-1:0] i_operand_a,
    input  logic [cfa_pkg::OUT_WIDTH-1:0] i_operand_b,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cfa_pkg::OUT_WIDTH-1:0] o_result_value,
    output logic [cfa_pkg::ST_WIDTH-1:0]  o_status
);
    import cfa_pkg::*;

    localparam int IW = item_width(DATA_WIDTH);

    logic          f_valid, f_ready, b_valid, b_ready;
    logic [IW-1:0] f_item, b_item;

    cfa_front #(.W(DATA_WIDTH), .IW(IW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .o_item_valid (f_valid),
        .i_item_ready (f_ready),
        .o_item       (f_item)
    );

    cfa_fifo #(.IW(IW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_item),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (b_item)
    );

    cfa_back #(.W(DATA_WIDTH), .IW(IW)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (b_valid),
        .o_item_ready   (b_ready),
        .i_item         (b_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

// ===== src/cfa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the checked signed ALU, bound to the top level.
// Depends on cfa_pkg and checked_signed_alu.
module cfa_checker #(
    parameter int W = cfa_pkg::DATA_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [cfa_pkg::OP_WIDTH-1:0]  i_opcode,
    input logic [cfa_pkg::OUT_WIDTH-1:0] i_operand_a,
    input logic [cfa_pkg::OUT_WIDTH-1:0] i_operand_b,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [cfa_pkg::OUT_WIDTH-1:0] o_result_value,
    input logic [cfa_pkg::ST_WIDTH-1:0]  o_status
);
    import cfa_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_opcode) && $stable(i_operand_a)
            && $stable(i_operand_b))
        else $error("input item changed while waiting");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_value) && $stable(o_status))
        else $error("output item changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_result_value == '0)
        else $error("error item with nonzero result");

    a_sext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_result_value[OUT_WIDTH-1:W-1] == '0
                     || o_result_value[OUT_WIDTH-1:W-1] == '1)
        else $error("result not sign-extended");

endmodule

bind checked_signed_alu cfa_checker #(.W(DATA_WIDTH)) u_cfa_checker (.*);
